// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the stable priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_DEPTH = 16;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_INSERT = 2'd0;
    localparam kind_t KIND_POP    = 2'd1;
    localparam kind_t KIND_CLEAR  = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  lvl_code;
        logic [6:0]  age;
        logic [15:0] tag;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   entry;
    } cell_cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  level;
        logic [6:0]  age;
        logic [15:0] tag;
    } req_beat_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  out_level;
        logic [6:0]  out_age;
        logic [15:0] out_tag;
        logic [4:0]  occupancy;
    } rsp_beat_t;

    function automatic logic [1:0] level_to_code(input logic [2:0] level);
        logic [1:0] code;
        if (level == 3'd0)
        begin
            code = 2'd0;
        end
        else if (level > 3'd4)
        begin
            code = 2'd3;
        end
        else
        begin
            code = 2'(level - 3'd1);
        end
        return code;
    endfunction

endpackage

// File: rtl/stable_priority_queue.sv
// The response to an accepted request beat is registered and valid in the next cycle.
// Throughput: one request beat per cycle while the response side is not stalled.
// Insert and pop are done by the row of cells in parallel.
// Reset clears the entry count and the response valid; cell contents are not reset.
// ----------------------------------------------------------------------------
// stable_priority_queue
// Four-level priority queue, FIFO within a level, built as a sorted row of cells.
// ----------------------------------------------------------------------------
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = SPQ_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    rsp_beat_t       rsp_reg;
    rsp_beat_t       rsp_next;

    logic            accept;
    logic            full;
    logic            empty;
    cell_cmd_t       cmd;

    entry_t          cell_entry [QUEUE_DEPTH];
    logic            cell_keep  [QUEUE_DEPTH];
    logic            cell_occ   [QUEUE_DEPTH];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CntW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        cmd.entry.lvl_code = level_to_code(req.level);
        cmd.entry.age      = req.age;
        cmd.entry.tag      = req.tag;
        cmd.op             = CELL_HOLD;
        count_next         = count_reg;
        rsp_next           = '0;
        rsp_next.status    = ST_OK;
        if (accept)
        begin
            unique case (req.kind)
                KIND_INSERT:
                begin
                    if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        cmd.op     = CELL_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_POP:
                begin
                    if (empty)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.op             = CELL_SHIFT;
                        count_next         = count_reg - 1'b1;
                        rsp_next.out_level = {1'b0, cell_entry[0].lvl_code} + 3'd1;
                        rsp_next.out_age   = cell_entry[0].age;
                        rsp_next.out_tag   = cell_entry[0].tag;
                    end
                end
                KIND_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        rsp_next.occupancy = 5'(count_next);
        rsp_valid_next     = accept ? 1'b1 : (rsp_valid_reg && rsp_stall);
    end

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            entry_t left_entry;
            logic   left_keep;
            entry_t right_entry;

            assign cell_occ[i] = (CntW'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign left_entry = '0;
                assign left_keep  = 1'b1;
            end
            else
            begin : g_body
                assign left_entry = cell_entry[i-1];
                assign left_keep  = cell_keep[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occ         (cell_occ[i]),
                .left_entry  (left_entry),
                .left_keep   (left_keep),
                .right_entry (right_entry),
                .entry       (cell_entry[i]),
                .keep        (cell_keep[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.kind == KIND_CLEAR |=> count_reg == '0)
        else $error("clear left entries");

    a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.kind == KIND_POP && !empty |=> rsp_valid && rsp.out_level != 3'd0
            && rsp.status == ST_OK)
        else $error("pop of held entry gave no level");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count moved without a beat");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.kind == KIND_INSERT && full |=> rsp.status == ST_FULL
            && $stable(count_reg))
        else $error("insert into full queue not dropped");

endmodule

// File: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds, takes the new entry, or takes a
// neighbor's entry, all from a broadcast command.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  logic      occ,
    input  entry_t    left_entry,
    input  logic      left_keep,
    input  entry_t    right_entry,
    output entry_t    entry,
    output logic      keep
);

    entry_t entry_reg;
    entry_t entry_next;

    assign keep  = occ && (entry_reg.lvl_code <= cmd.entry.lvl_code);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            CELL_INSERT:
            begin
                if (!keep)
                begin
                    entry_next = left_keep ? cmd.entry : left_entry;
                end
            end
            CELL_SHIFT:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
